@@ rtl/core/stl_pkg.sv @@
// Package for the slot table with token lookup.
// Request kinds, result status codes and the default table depth.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int SLOT_W = 4;
  localparam int WORD_W = 32;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_EDIT   = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/slot_table_with_token_lookup.sv @@
// Slot table with first-free allocation and lookup by token.
// Depends on stl_pkg (kind and status codes, field widths, default depth).
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. kind picks
//   add, edit, delete or lookup; slot, token and payload come with it.
//   Each item gives exactly one result, shown for one cycle with done high on
//   status, result_slot, found_token and found_payload. The receiver cannot
//   stall; the result registers are separate from the sequencer, so a new item
//   may be taken in the same cycle a result is shown.
// Timing:
//   Edit and delete finish at the accepting edge: done is high in the next
//   cycle and busy never rises.
//   Add walks the valid bits one slot a cycle from slot 0 and stops at the
//   first free slot, or with status full after the last slot.
//   Lookup walks the token memory one slot a cycle through its registered
//   read port and stops at the first valid slot whose token matches, or
//   with status not found after the last slot.
// Reset:
//   rst (synchronous) clears all valid bits and the sequencer; token and data
//   memories are not cleared, since a slot is only read once it is valid.
`timescale 1ns / 1ps
`default_nettype none

module slot_table_with_token_lookup #(
  parameter int DEPTH = stl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        kind,
  input  wire logic [stl_pkg::SLOT_W-1:0]        slot,
  input  wire logic signed [stl_pkg::WORD_W-1:0] token,
  input  wire logic signed [stl_pkg::WORD_W-1:0] payload,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [stl_pkg::SLOT_W-1:0]             result_slot,
  output logic signed [stl_pkg::WORD_W-1:0]      found_token,
  output logic signed [stl_pkg::WORD_W-1:0]      found_payload
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // compare width: holds DEPTH itself and the 4-bit slot field
  localparam int CW = (AW + 1 > stl_pkg::SLOT_W + 1) ? AW + 1 : stl_pkg::SLOT_W + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;

  logic [1:0]    state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          chk;
  logic [AW-1:0] chk_idx;

  logic [stl_pkg::WORD_W-1:0] req_token;
  logic [stl_pkg::WORD_W-1:0] req_payload;

  logic [DEPTH-1:0] valid;
  logic [stl_pkg::WORD_W-1:0] tok_mem [DEPTH];
  logic [stl_pkg::WORD_W-1:0] pay_mem [DEPTH];
  logic [stl_pkg::WORD_W-1:0] tok_rd;
  logic [stl_pkg::WORD_W-1:0] pay_rd;

  logic          accept;
  logic [CW-1:0] slot_ext;
  logic          slot_ok;
  logic [AW-1:0] slot_idx;
  logic          hit;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [stl_pkg::WORD_W-1:0] wr_tok;
  logic [stl_pkg::WORD_W-1:0] wr_pay;

  logic                       res_en;
  logic [1:0]                 res_status;
  logic [AW-1:0]              res_idx;
  logic                       res_found;

  function automatic logic [stl_pkg::SLOT_W-1:0] slot_ext_of(input logic [AW-1:0] idx);
    logic [CW-1:0] wide;
    wide = CW'(idx);
    return wide[stl_pkg::SLOT_W-1:0];
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = {{(CW - stl_pkg::SLOT_W){1'b0}}, slot};
  assign slot_ok  = (slot_ext < CW'(DEPTH));
  assign slot_idx = slot_ext[AW-1:0];
  assign hit      = chk && valid[chk_idx] && (tok_rd == req_token);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wr_en      = 1'b0;
    wr_addr    = slot_idx;
    wr_tok     = token;
    wr_pay     = payload;
    res_en     = 1'b0;
    res_status = stl_pkg::ST_NOT_FOUND;
    res_idx    = '0;
    res_found  = 1'b0;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          case (kind)
            stl_pkg::KIND_ADD: begin
              state_next = S_ADD;
            end
            stl_pkg::KIND_EDIT: begin
              res_en     = 1'b1;
              wr_en      = slot_ok;
              res_status = slot_ok ? stl_pkg::ST_OK : stl_pkg::ST_NOT_FOUND;
            end
            stl_pkg::KIND_DELETE: begin
              res_en     = 1'b1;
              res_status = slot_ok ? stl_pkg::ST_OK : stl_pkg::ST_NOT_FOUND;
            end
            default: begin
              state_next = S_LOOK;
            end
          endcase
        end
      end
      S_ADD: begin
        wr_addr = cnt;
        wr_tok  = req_token;
        wr_pay  = req_payload;
        if (!valid[cnt]) begin
          wr_en      = 1'b1;
          res_en     = 1'b1;
          res_status = stl_pkg::ST_OK;
          res_idx    = cnt;
          state_next = S_IDLE;
        end else if (cnt == LAST) begin
          res_en     = 1'b1;
          res_status = stl_pkg::ST_FULL;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_LOOK: begin
        // read of cnt issued this cycle; compare of chk_idx data
        if (cnt != LAST) begin
          cnt_next = cnt + 1'b1;
        end
        if (hit) begin
          res_en     = 1'b1;
          res_status = stl_pkg::ST_OK;
          res_idx    = chk_idx;
          res_found  = 1'b1;
          state_next = S_IDLE;
        end else if (chk && chk_idx == LAST) begin
          res_en     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      chk   <= 1'b0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      // compare only while the scan goes on, never in the idle cycle after it
      chk   <= (state == S_LOOK) && (state_next == S_LOOK);
      done  <= res_en;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (accept && kind == stl_pkg::KIND_DELETE && slot_ok) begin
        valid[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= cnt;
    if (accept) begin
      req_token   <= token;
      req_payload <= payload;
    end
    if (res_en) begin
      status        <= res_status;
      result_slot   <= slot_ext_of(res_idx);
      found_token   <= res_found ? tok_rd : '0;
      found_payload <= res_found ? pay_rd : '0;
    end
  end

  // token and data memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[wr_addr] <= wr_tok;
      pay_mem[wr_addr] <= wr_pay;
    end
    tok_rd <= tok_mem[cnt];
    pay_rd <= pay_mem[cnt];
  end

  // a result only follows an accepted item or a running scan
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("done without a request");

  // failed requests return all-zero slot and data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != stl_pkg::ST_OK |->
      result_slot == '0 && found_token == '0 && found_payload == '0)
    else $error("failed request returned nonzero fields");

  // a lookup hit always reports a slot that is valid
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    hit |-> valid[chk_idx] && state == S_LOOK)
    else $error("hit outside lookup scan");

  // busy implies the sequencer state was not idle in that cycle
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !(state == S_IDLE && $past(state) == S_IDLE))
    else $error("sequencer state inconsistent with busy");

endmodule

`default_nettype wire

@@ tb/sv/slot_table_with_token_lookup_tb.sv @@
// Testbench for slot_table_with_token_lookup: directed and random requests against
// a cycle-free mirror of the slot table, one result checked per request.
// Depends on stl_pkg and the slot_table_with_token_lookup RTL.
`timescale 1ns / 1ps

module slot_table_with_token_lookup_tb;

  localparam int DEPTH      = stl_pkg::DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 2 * DEPTH + 8;
  localparam logic [31:0] DUP_TOKEN = 32'hA5A5_5A5A;

  typedef struct packed {
    logic [1:0]                 status;
    logic [stl_pkg::SLOT_W-1:0] slot;
    logic [stl_pkg::WORD_W-1:0] tok;
    logic [stl_pkg::WORD_W-1:0] pay;
  } table_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic [1:0]                        kind = stl_pkg::KIND_LOOKUP;
  logic [stl_pkg::SLOT_W-1:0]        slot = '0;
  logic signed [stl_pkg::WORD_W-1:0] token = '0;
  logic signed [stl_pkg::WORD_W-1:0] payload = '0;
  logic                              busy;
  logic                              done;
  logic [1:0]                        status;
  logic [stl_pkg::SLOT_W-1:0]        result_slot;
  logic signed [stl_pkg::WORD_W-1:0] found_token;
  logic signed [stl_pkg::WORD_W-1:0] found_payload;

  // mirror of the table contents
  bit                         slot_used [DEPTH];
  logic [stl_pkg::WORD_W-1:0] slot_tok  [DEPTH];
  logic [stl_pkg::WORD_W-1:0] slot_pay  [DEPTH];

  table_result_t pending_results[$];
  int            error_count = 0;
  int            idle_pct = 0;
  int            idle_cycles = 0;

  logic [stl_pkg::WORD_W-1:0] token_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                  32'h8000_0000, 32'h7FFF_FFFF,
                                                  32'h0000_0001, DUP_TOKEN};

  slot_table_with_token_lookup #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .slot(slot), .token(token), .payload(payload),
    .done(done), .status(status), .result_slot(result_slot),
    .found_token(found_token), .found_payload(found_payload)
  );

  always #4 clk = ~clk;

  // Applies one request to the mirror and returns the result it must give.
  function automatic table_result_t predict_table(input logic [1:0] k, input logic [3:0] s,
                                                  input logic [31:0] t, input logic [31:0] p);
    table_result_t r;
    bit            hit;
    r = '0;
    r.status = stl_pkg::ST_NOT_FOUND;
    hit = 1'b0;
    case (k)
      stl_pkg::KIND_ADD: begin
        r.status = stl_pkg::ST_FULL;
        for (int i = 0; i < DEPTH; i++) begin
          if (!hit && !slot_used[i]) begin
            hit = 1'b1;
            slot_used[i] = 1'b1;
            slot_tok[i] = t;
            slot_pay[i] = p;
            r.status = stl_pkg::ST_OK;
            r.slot = stl_pkg::SLOT_W'(i);
          end
        end
      end
      stl_pkg::KIND_EDIT: begin
        if (int'(s) < DEPTH) begin
          slot_used[s] = 1'b1;
          slot_tok[s] = t;
          slot_pay[s] = p;
          r.status = stl_pkg::ST_OK;
        end
      end
      stl_pkg::KIND_DELETE: begin
        if (int'(s) < DEPTH) begin
          slot_used[s] = 1'b0;
          r.status = stl_pkg::ST_OK;
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!hit && slot_used[i] && slot_tok[i] == t) begin
            hit = 1'b1;
            r.status = stl_pkg::ST_OK;
            r.slot = stl_pkg::SLOT_W'(i);
            r.tok = slot_tok[i];
            r.pay = slot_pay[i];
          end
        end
      end
    endcase
    return r;
  endfunction

  // Caller sits at a rising edge; start is left high so back-to-back items need no toggle.
  task automatic send_request(input logic [1:0] k, input logic [3:0] s,
                              input logic [31:0] t, input logic [31:0] p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    kind    <= k;
    slot    <= s;
    token   <= t;
    payload <= p;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_table(k, s, t, p));
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_token();
    if ($urandom_range(99) < 50) return token_pool[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic test_empty_table();
    send_request(stl_pkg::KIND_LOOKUP, 4'd0, 32'h0, 32'h0);
    send_request(stl_pkg::KIND_DELETE, 4'd15, 32'h0, 32'h0);  // delete of a free slot
  endtask

  task automatic test_fill_to_full();
    logic [31:0] t;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       t = 32'h8000_0000;
        1:       t = 32'h7FFF_FFFF;
        2:       t = 32'h0000_0000;
        3:       t = 32'hFFFF_FFFF;
        default: t = (i % 3 == 1) ? DUP_TOKEN : {16'hC0DE, 12'h0, 4'(i)};
      endcase
      send_request(stl_pkg::KIND_ADD, 4'($urandom), t, ~t ^ {28'h0, 4'(i)});
    end
    send_request(stl_pkg::KIND_ADD, 4'hF, 32'h1234_5678, 32'h8765_4321);  // pool full
  endtask

  task automatic test_duplicate_tokens();
    send_request(stl_pkg::KIND_LOOKUP, 4'($urandom), DUP_TOKEN, 32'h0);  // lowest of several
    send_request(stl_pkg::KIND_DELETE, 4'd4, 32'h0, 32'h0);
    send_request(stl_pkg::KIND_LOOKUP, 4'($urandom), DUP_TOKEN, 32'h0);
    send_request(stl_pkg::KIND_EDIT, 4'd4, 32'h8000_0000, 32'h5555_AAAA);
    send_request(stl_pkg::KIND_LOOKUP, 4'd0, 32'h8000_0000, 32'h0);
  endtask

  task automatic test_edit_free_slot();
    send_request(stl_pkg::KIND_DELETE, 4'd0, 32'h0, 32'h0);
    send_request(stl_pkg::KIND_LOOKUP, 4'd0, 32'h8000_0000, 32'h0);
    // free slot becomes valid
    send_request(stl_pkg::KIND_EDIT, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(stl_pkg::KIND_LOOKUP, 4'd0, 32'hFFFF_FFFF, 32'h0);
    send_request(stl_pkg::KIND_EDIT, 4'd15, 32'h0000_0000, 32'h7FFF_FFFF);
  endtask

  // Bursts lean toward filling or toward draining so both full and empty tables show up.
  task automatic test_random_traffic(input int n_items);
    bit          fill_bias;
    int          r;
    int          pick;
    logic [1:0]  k;
    logic [31:0] t;
    fill_bias = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 32 == 0) fill_bias = 1'($urandom_range(1));
      if (n == n_items / 2) wait_for_drain();
      r = $urandom_range(99);
      if (fill_bias) k = (r < 45) ? stl_pkg::KIND_ADD : (r < 60) ? stl_pkg::KIND_EDIT :
                         (r < 70) ? stl_pkg::KIND_DELETE : stl_pkg::KIND_LOOKUP;
      else           k = (r < 10) ? stl_pkg::KIND_ADD : (r < 20) ? stl_pkg::KIND_EDIT :
                         (r < 65) ? stl_pkg::KIND_DELETE : stl_pkg::KIND_LOOKUP;
      t = pick_token();
      if (k == stl_pkg::KIND_LOOKUP) begin
        pick = $urandom_range(DEPTH - 1);
        if (slot_used[pick] && $urandom_range(99) < 70) t = slot_tok[pick];
      end
      send_request(k, 4'($urandom), t, $urandom);
    end
  endtask

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d slot %0d", status, result_slot);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, result_slot);
          error_count++;
        end
        if (found_token !== want.tok) begin
          $error("found_token: expected %h, got %h", want.tok, found_token);
          error_count++;
        end
        if (found_payload !== want.pay) begin
          $error("found_payload: expected %h, got %h", want.pay, found_payload);
          error_count++;
        end
      end
    end
  end

  // counts cycles with neither an accepted item nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 10;
    test_empty_table();
    test_fill_to_full();
    test_duplicate_tokens();
    test_edit_free_slot();
    wait_for_drain();
    idle_pct = 35;
    test_random_traffic(400);
    idle_pct = 54;
    test_random_traffic(400);
    idle_pct = 0;
    test_random_traffic(400);
    wait_for_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
